// ===== rtl/svm_pkg.sv =====
package svm_pkg;

    typedef enum logic [2:0] {
        KIND_LOAD   = 3'd0,
        KIND_PLAY   = 3'd1,
        KIND_STOP   = 3'd2,
        KIND_VOLUME = 3'd3,
        KIND_PAN    = 3'd4,
        KIND_STEP   = 3'd5,
        KIND_TICK   = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_ISSUE,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec_write;
        logic idx_clr;
        logic idx_inc;
        logic play_take;
        logic play_full;
        logic tick_issue;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        kind_t kind;
        logic  idx_free;
        logic  idx_last;
        logic  pipe_busy;
        logic  out_free;
    } ctrl_stat_t;

    localparam int IN_W    = 96;
    localparam int OUT_W   = 56;
    localparam int ACC_W   = 40;
    localparam int Q14_ONE = 16384;
    localparam logic [16:0] POS_MAX = 17'h1FFFF;

endpackage

// ===== rtl/sample_voice_mixer.sv =====
// Multi-voice PCM mixer with a sample store of SAMPLE_DEPTH words (a power of two) and
// VOICES voice slots. Commands arrive on the s_ stream, kind in s_tuser; one command is
// taken at a time. Play scans the slots for the lowest free one, one slot per cycle,
// and answers on the m_ stream. A tick streams the voice table through a four-stage
// mix pipeline, one voice per cycle, and returns one stereo frame. A finished result
// waits in the output register while the next command is taken.
module sample_voice_mixer #(
    parameter int VOICES       = 64,
    parameter int SAMPLE_DEPTH = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // address, sample_value, length, voice, volume, pan, pitch_step, zero pad
    input  logic [95:0] s_tdata,
    // kind
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // play: slot_id, no_free_voice, zero pad; tick: zero pad, left_sum, right_sum, zero pad
    output logic [55:0] m_tdata,
    // result_kind
    output logic [0:0]  m_tuser
);

    svm_pkg::ctrl_cmd_t  cmd;
    svm_pkg::ctrl_stat_t stat;

    svm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    svm_datapath #(
        .VOICES       (VOICES),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_kind   (s_tuser),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_kind  (m_tuser[0]),
        .out_data  (m_tdata)
    );

endmodule

// ===== rtl/svm_ctrl.sv =====
module svm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  svm_pkg::ctrl_stat_t stat,
    output svm_pkg::ctrl_cmd_t  cmd
);

    svm_pkg::state_t state_reg;
    svm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= svm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            svm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = svm_pkg::ST_EXEC;
                end
            end
            svm_pkg::ST_EXEC:
            begin
                cmd.idx_clr = 1'b1;
                unique case (stat.kind)
                    svm_pkg::KIND_PLAY: state_next = svm_pkg::ST_SCAN;
                    svm_pkg::KIND_TICK: state_next = svm_pkg::ST_ISSUE;
                    default:
                    begin
                        cmd.exec_write = 1'b1;
                        state_next     = svm_pkg::ST_IDLE;
                    end
                endcase
            end
            svm_pkg::ST_SCAN:
            begin
                priority if (stat.idx_free)
                begin
                    cmd.play_take = 1'b1;
                    state_next    = svm_pkg::ST_RESULT;
                end
                else if (stat.idx_last)
                begin
                    cmd.play_full = 1'b1;
                    state_next    = svm_pkg::ST_RESULT;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            svm_pkg::ST_ISSUE:
            begin
                cmd.tick_issue = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = svm_pkg::ST_DRAIN;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            svm_pkg::ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = svm_pkg::ST_RESULT;
                end
            end
            svm_pkg::ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = svm_pkg::ST_IDLE;
                end
            end
            default: state_next = svm_pkg::ST_IDLE;
        endcase
    end

    a_inc_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.idx_inc |-> !stat.idx_last)
        else $error("voice index stepped past the last slot");

endmodule

// ===== rtl/svm_datapath.sv =====
module svm_datapath #(
    parameter int VOICES       = 64,
    parameter int SAMPLE_DEPTH = 65536
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [2:0]                   in_kind,
    input  logic [svm_pkg::IN_W-1:0]     in_data,
    input  svm_pkg::ctrl_cmd_t           cmd,
    output svm_pkg::ctrl_stat_t          stat,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic                         out_kind,
    output logic [svm_pkg::OUT_W-1:0]    out_data
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AW = $clog2(SAMPLE_DEPTH);

    // Captured command.
    svm_pkg::kind_t     kind_reg;
    logic [15:0]        addr_reg;
    logic signed [15:0] sval_reg;
    logic [16:0]        len_reg;
    logic [5:0]         voice_reg;
    logic [15:0]        vol_reg;
    logic signed [15:0] pan_reg;
    logic [3:0]         step_reg;

    logic signed [15:0] in_pan;
    logic signed [15:0] pan_cl;

    assign in_pan = in_data[86:71];
    always_comb
    begin
        priority if (in_pan > 16'sd16384)
        begin
            pan_cl = 16'sd16384;
        end
        else if (in_pan < -16'sd16384)
        begin
            pan_cl = -16'sd16384;
        end
        else
        begin
            pan_cl = in_pan;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= svm_pkg::kind_t'(in_kind);
            addr_reg  <= in_data[15:0];
            sval_reg  <= in_data[31:16];
            len_reg   <= in_data[48:32];
            voice_reg <= in_data[54:49];
            vol_reg   <= in_data[70:55];
            pan_reg   <= pan_cl;
            step_reg  <= in_data[90:87];
        end
    end

    // Voice table and sample store.
    logic [VOICES-1:0]  active_reg;
    logic [15:0]        start_mem [VOICES];
    logic [16:0]        len_mem   [VOICES];
    logic [16:0]        pos_mem   [VOICES];
    logic [15:0]        gain_mem  [VOICES];
    logic signed [15:0] bal_mem   [VOICES];
    logic [3:0]         step_mem  [VOICES];
    logic signed [15:0] sample_mem [SAMPLE_DEPTH];

    logic [VW-1:0] idx_reg;
    logic [VW-1:0] sel;
    logic          voice_ok;
    logic          play_nofree_reg;

    assign sel      = VW'(voice_reg);
    assign voice_ok = 9'(voice_reg) < 9'(VOICES);

    // Tick pipeline: A has the table entry, B has gains and sample, C has products.
    logic               va_reg, act_a_reg;
    logic [VW-1:0]      idx_a_reg;
    logic [15:0]        start_a_reg, gain_a_reg;
    logic [16:0]        len_a_reg, pos_a_reg;
    logic signed [15:0] bal_a_reg;
    logic [3:0]         step_a_reg;
    logic               vb_reg;
    logic [15:0]        gl_b_reg, gr_b_reg;
    logic signed [15:0] samp_b_reg;
    logic               vc_reg;
    logic signed [31:0] pl_c_reg, pr_c_reg;
    logic signed [svm_pkg::ACC_W-1:0] acc_l_reg, acc_r_reg;

    logic               live_a, end_a;
    logic signed [17:0] fl_raw, fr_raw;
    logic [14:0]        fac_l, fac_r;
    logic [17:0]        pos_sum;
    logic [16:0]        pos_new;
    logic [AW-1:0]      samp_addr;
    logic signed [32:0] pl, pr;

    assign live_a = va_reg && act_a_reg && (pos_a_reg < len_a_reg);
    assign end_a  = va_reg && act_a_reg && !(pos_a_reg < len_a_reg);
    assign fl_raw = 18'sd16384 - 18'(bal_a_reg);
    assign fr_raw = 18'sd16384 + 18'(bal_a_reg);
    assign fac_l  = (fl_raw > 18'sd16384) ? 15'd16384 : fl_raw[14:0];
    assign fac_r  = (fr_raw > 18'sd16384) ? 15'd16384 : fr_raw[14:0];
    assign pos_sum = 18'(pos_a_reg) + 18'(step_a_reg);
    assign pos_new = (pos_sum > 18'(svm_pkg::POS_MAX)) ? svm_pkg::POS_MAX : pos_sum[16:0];
    assign samp_addr = AW'(18'(start_a_reg) + 18'(pos_a_reg));
    assign pl = samp_b_reg * $signed({1'b0, gl_b_reg});
    assign pr = samp_b_reg * $signed({1'b0, gr_b_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.exec_write && kind_reg == svm_pkg::KIND_LOAD)
        begin
            sample_mem[AW'(addr_reg)] <= sval_reg;
        end
        samp_b_reg <= sample_mem[samp_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.play_take)
        begin
            start_mem[idx_reg] <= addr_reg;
            len_mem[idx_reg]   <= len_reg;
            pos_mem[idx_reg]   <= '0;
            gain_mem[idx_reg]  <= vol_reg;
            bal_mem[idx_reg]   <= pan_reg;
            step_mem[idx_reg]  <= 4'd1;
        end
        else if (cmd.exec_write && voice_ok)
        begin
            unique case (kind_reg)
                svm_pkg::KIND_VOLUME: gain_mem[sel] <= vol_reg;
                svm_pkg::KIND_PAN:    bal_mem[sel]  <= pan_reg;
                svm_pkg::KIND_STEP:   step_mem[sel] <= step_reg;
                default: ;
            endcase
        end
        if (live_a)
        begin
            pos_mem[idx_a_reg] <= pos_new;
        end
        start_a_reg <= start_mem[idx_reg];
        len_a_reg   <= len_mem[idx_reg];
        pos_a_reg   <= pos_mem[idx_reg];
        gain_a_reg  <= gain_mem[idx_reg];
        bal_a_reg   <= bal_mem[idx_reg];
        step_a_reg  <= step_mem[idx_reg];
        act_a_reg   <= active_reg[idx_reg];
        idx_a_reg   <= idx_reg;
        gl_b_reg    <= 16'((32'(gain_a_reg) * 32'(fac_l)) >> 14);
        gr_b_reg    <= 16'((32'(gain_a_reg) * 32'(fac_r)) >> 14);
        pl_c_reg    <= 32'(pl);
        pr_c_reg    <= 32'(pr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= '0;
            idx_reg         <= '0;
            va_reg          <= 1'b0;
            vb_reg          <= 1'b0;
            vc_reg          <= 1'b0;
            out_valid       <= 1'b0;
            play_nofree_reg <= 1'b0;
        end
        else
        begin
            if (end_a)
            begin
                active_reg[idx_a_reg] <= 1'b0;
            end
            if (cmd.exec_write && voice_ok && kind_reg == svm_pkg::KIND_STOP)
            begin
                active_reg[sel] <= 1'b0;
            end
            if (cmd.play_take)
            begin
                active_reg[idx_reg] <= 1'b1;
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            va_reg <= cmd.tick_issue;
            vb_reg <= live_a;
            vc_reg <= vb_reg;
            if (cmd.play_take)
            begin
                play_nofree_reg <= 1'b0;
            end
            else if (cmd.play_full)
            begin
                play_nofree_reg <= 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.idx_clr)
        begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        else if (vc_reg)
        begin
            acc_l_reg <= acc_l_reg + svm_pkg::ACC_W'(pl_c_reg);
            acc_r_reg <= acc_r_reg + svm_pkg::ACC_W'(pr_c_reg);
        end
        if (cmd.load_out)
        begin
            if (kind_reg == svm_pkg::KIND_PLAY)
            begin
                out_kind <= 1'b1;
                out_data <= {49'd0, play_nofree_reg,
                             play_nofree_reg ? 6'd0 : 6'(idx_reg)};
            end
            else
            begin
                out_kind <= 1'b0;
                out_data <= {1'b0, acc_r_reg[37:14], acc_l_reg[37:14], 7'd0};
            end
        end
    end

    assign stat = '{
        kind:      kind_reg,
        idx_free:  !active_reg[idx_reg],
        idx_last:  idx_reg == VW'(VOICES - 1),
        pipe_busy: va_reg || vb_reg || vc_reg,
        out_free:  !out_valid || out_ready
    };

    a_take_sets_active: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.play_take |=> active_reg[$past(idx_reg)])
        else $error("started voice not marked active");

    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        vb_reg |-> $past(va_reg))
        else $error("tick pipeline stage B without stage A");

    a_frame_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && kind_reg == svm_pkg::KIND_TICK) |-> !stat.pipe_busy)
        else $error("frame loaded while tick pipeline busy");

    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || out_ready))
        else $error("result register overwritten before transfer");

endmodule
